FILE: hdl/mck_pkg.sv
// Shared types and constants for the Morse code keyer.
`timescale 1ns / 1ps
`default_nettype none
package mck_pkg;

	// Element lengths in keying units
	localparam logic [1:0] DOT_MARK   = 2'd1;
	localparam logic [1:0] DASH_MARK  = 2'd3;
	localparam logic [1:0] SYM_GAP    = 2'd1;
	localparam logic [1:0] CHAR_GAP   = 2'd2;
	localparam logic [1:0] MSG_GAP    = 2'd2;
	localparam logic [1:0] NO_UNITS   = 2'd0;

	// ASCII landmarks
	localparam logic [7:0] ASCII_LOWER_A = 8'h61;
	localparam logic [7:0] ASCII_LOWER_Z = 8'h7a;
	localparam logic [7:0] ASCII_UPPER_A = 8'h41;
	localparam logic [7:0] ASCII_UPPER_Z = 8'h5a;
	localparam logic [7:0] ASCII_ZERO    = 8'h30;
	localparam logic [7:0] ASCII_NINE    = 8'h39;
	localparam logic [7:0] ASCII_SPACE   = 8'h20;

	// Rows 0..25 letters, 26..35 digits
	localparam int unsigned NUM_ROWS  = 36;
	localparam logic [5:0]  DIGIT_ROW = 6'd26;

	// Code word: {symbol count, pattern}; pattern bit k set means symbol k is a dash
	typedef struct packed {
		logic [2:0] len;
		logic [4:0] pat;
	} code_t;

	localparam code_t CODE_TABLE [NUM_ROWS] = '{
		'{3'd2, 5'b00010}, '{3'd4, 5'b00001}, '{3'd4, 5'b00101}, '{3'd3, 5'b00001},
		'{3'd1, 5'b00000}, '{3'd4, 5'b00100}, '{3'd3, 5'b00011}, '{3'd4, 5'b00000},
		'{3'd2, 5'b00000}, '{3'd4, 5'b01110}, '{3'd3, 5'b00101}, '{3'd4, 5'b00010},
		'{3'd2, 5'b00011}, '{3'd2, 5'b00001}, '{3'd3, 5'b00111}, '{3'd4, 5'b00110},
		'{3'd4, 5'b01011}, '{3'd3, 5'b00010}, '{3'd3, 5'b00000}, '{3'd1, 5'b00001},
		'{3'd3, 5'b00100}, '{3'd4, 5'b01000}, '{3'd3, 5'b00110}, '{3'd4, 5'b01001},
		'{3'd4, 5'b01101}, '{3'd4, 5'b00011},
		'{3'd5, 5'b11111}, '{3'd5, 5'b11110}, '{3'd5, 5'b11100}, '{3'd5, 5'b11000},
		'{3'd5, 5'b10000}, '{3'd5, 5'b00000}, '{3'd5, 5'b00001}, '{3'd5, 5'b00011},
		'{3'd5, 5'b00111}, '{3'd5, 5'b01111}
	};

	// Decoded character, handed from the decoder to the sequencer
	typedef struct packed {
		code_t code;
		logic  is_space;
		logic  unsup;
	} char_info_t;

endpackage
`default_nettype wire

FILE: hdl/mck_decode.sv
// Character decoder: maps an ASCII code to its Morse code word and class flags.
`timescale 1ns / 1ps
`default_nettype none
module mck_decode (
	input  wire logic [7:0]          character,
	output mck_pkg::char_info_t      info
);
	import mck_pkg::*;

	logic       is_lower;
	logic       is_upper;
	logic       is_digit;
	logic [7:0] offset;
	logic [5:0] row;

	// Classify the code
	always_comb begin
		is_lower = (character >= ASCII_LOWER_A) && (character <= ASCII_LOWER_Z);
		is_upper = (character >= ASCII_UPPER_A) && (character <= ASCII_UPPER_Z);
		is_digit = (character >= ASCII_ZERO) && (character <= ASCII_NINE);
	end

	// Table row; letters fold case, digits follow the letters
	always_comb begin
		offset = 8'd0;
		row    = 6'd0;
		if (is_lower) begin
			offset = character - ASCII_LOWER_A;
			row    = offset[5:0];
		end else if (is_upper) begin
			offset = character - ASCII_UPPER_A;
			row    = offset[5:0];
		end else if (is_digit) begin
			offset = character - ASCII_ZERO;
			row    = DIGIT_ROW + offset[5:0];
		end
	end

	// Lookup and flags
	always_comb begin
		info.code     = CODE_TABLE[row];
		info.is_space = (character == ASCII_SPACE);
		info.unsup    = !(is_lower || is_upper || is_digit) && (character != ASCII_SPACE);
	end

endmodule
`default_nettype wire

FILE: hdl/morse_code_keyer_top.sv
// Top level of the Morse code keyer: microcoded element sequencer.
`timescale 1ns / 1ps
`default_nettype none
// Morse code keyer.
// Command side: an item (character, ends_message) is taken at a rising edge
// where start is high and busy is low. busy then stays high while the item's
// elements go out.
// Result side: each element (mark_units, gap_units, unsupported, last) is on
// the outputs for exactly one cycle with strobe high; last marks the final
// element of the item. The receiver cannot stall, so one element leaves
// every cycle while busy is high.
// The first element appears in the cycle after the item is taken.
// An item has 1 to 7 elements, and busy stays high until the last of them
// has gone out; no new item is taken while busy is high. The elements come
// from the microcode program, one element per step: symbols, character
// gap, optional message gap.
// Reset (arst_n low) clears busy and the step counter at once; nothing else
// needs clearing.
module morse_code_keyer_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [7:0] character,
	input  wire logic       ends_message,
	output logic            strobe,
	output logic [1:0]      mark_units,
	output logic [1:0]      gap_units,
	output logic            unsupported,
	output logic            last
);
	import mck_pkg::*;

	// Microcode addresses
	typedef enum logic [1:0] {
		UPC_SYM  = 2'd0,
		UPC_CGAP = 2'd1,
		UPC_MGAP = 2'd2,
		UPC_UNS  = 2'd3
	} upc_t;

	// Branch conditions
	typedef enum logic [1:0] {
		COND_ALWAYS  = 2'd0,
		COND_SYM_END = 2'd1,
		COND_MSG     = 2'd2
	} cond_t;

	// One control word per step
	typedef struct packed {
		logic       mark_sym;
		logic [1:0] gap;
		logic       unsup;
		cond_t      cond;
		upc_t       nxt_t;
		logic       end_t;
		upc_t       nxt_f;
		logic       end_f;
	} ucw_t;

	char_info_t info;
	ucw_t       ucw;
	upc_t       upc_q;
	logic       busy_q;
	logic       msg_q;
	logic [2:0] len_q;
	logic [2:0] cnt_q;
	logic [4:0] pat_q;
	logic [2:0] cnt_inc;
	logic       cond_hit;
	logic       end_now;
	upc_t       upc_nxt;
	logic       accept;

	mck_decode u_decode (
		.character (character),
		.info      (info)
	);

	// Control store
	always_comb begin
		case (upc_q)
			UPC_SYM:  ucw = '{1'b1, SYM_GAP,  1'b0, COND_SYM_END,
				UPC_CGAP, 1'b0, UPC_SYM, 1'b0};
			UPC_CGAP: ucw = '{1'b0, CHAR_GAP, 1'b0, COND_MSG,
				UPC_MGAP, 1'b0, UPC_CGAP, 1'b1};
			UPC_MGAP: ucw = '{1'b0, MSG_GAP,  1'b0, COND_ALWAYS,
				UPC_MGAP, 1'b1, UPC_MGAP, 1'b1};
			UPC_UNS:  ucw = '{1'b0, NO_UNITS, 1'b1, COND_ALWAYS,
				UPC_UNS, 1'b1, UPC_UNS, 1'b1};
			default:  ucw = '{1'b0, NO_UNITS, 1'b0, COND_ALWAYS,
				UPC_SYM, 1'b1, UPC_SYM, 1'b1};
		endcase
	end

	// Branch evaluation
	always_comb begin
		cnt_inc = cnt_q + 3'd1;
		case (ucw.cond)
			COND_ALWAYS:  cond_hit = 1'b1;
			COND_SYM_END: cond_hit = (cnt_inc == len_q);
			COND_MSG:     cond_hit = msg_q;
			default:      cond_hit = 1'b1;
		endcase
		upc_nxt = cond_hit ? ucw.nxt_t : ucw.nxt_f;
		end_now = cond_hit ? ucw.end_t : ucw.end_f;
	end

	assign accept = start && !busy_q;

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			upc_q  <= UPC_SYM;
		end else if (accept) begin
			busy_q <= 1'b1;
			if (info.unsup) begin
				upc_q <= UPC_UNS;
			end else if (info.is_space) begin
				upc_q <= UPC_CGAP;
			end else begin
				upc_q <= UPC_SYM;
			end
		end else if (busy_q) begin
			busy_q <= !end_now;
			upc_q  <= upc_nxt;
		end
	end

	// Datapath: symbol pattern shifter and counter
	always_ff @(posedge clk) begin
		if (accept) begin
			msg_q <= ends_message;
			len_q <= info.code.len;
			pat_q <= info.code.pat;
			cnt_q <= 3'd0;
		end else if (busy_q && ucw.mark_sym) begin
			pat_q <= {1'b0, pat_q[4:1]};
			cnt_q <= cnt_inc;
		end
	end

	// Result outputs
	always_comb begin
		busy        = busy_q;
		strobe      = busy_q;
		mark_units  = ucw.mark_sym ? (pat_q[0] ? DASH_MARK : DOT_MARK) : NO_UNITS;
		gap_units   = ucw.gap;
		unsupported = ucw.unsup;
		last        = end_now;
	end

endmodule
`default_nettype wire

FILE: tb/keyer_element_checker.sv
// Checker for the Morse keyer: expands each accepted character and compares every element.
`timescale 1ns / 1ps
module keyer_element_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       busy,
	input  logic [7:0] character,
	input  logic       ends_message,
	input  logic       strobe,
	input  logic [1:0] mark_units,
	input  logic [1:0] gap_units,
	input  logic       unsupported,
	input  logic       last,
	output int         fail_count,
	output int         outstanding
);
	import mck_pkg::*;

	typedef struct packed {
		logic [1:0] mark;
		logic [1:0] gap;
		logic       unsup;
		logic       fin;
	} element_t;

	// Elements still to come, oldest first
	element_t due_elements[$];

	// Letters a..z, then digits 0..9
	string morse_words [36] = '{
		".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....",
		"..", ".---", "-.-", ".-..", "--", "-.", "---", ".--.",
		"--.-", ".-.", "...", "-", "..-", "...-", ".--", "-..-",
		"-.--", "--..",
		"-----", ".----", "..---", "...--", "....-", ".....", "-....", "--...",
		"---..", "----."
	};

	initial begin
		fail_count  = 0;
		outstanding = 0;
	end

	task automatic report_mismatch(input string what);
		$display("%0t ns: ERROR %s", $realtime, what);
		fail_count++;
	endtask

	// Queue up the elements one character should produce
	task automatic expand_character(input logic [7:0] c, input logic msg_end);
		int       row;
		int       k;
		string    word;
		element_t el;
		row = -1;
		if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z)
			row = int'(c - ASCII_LOWER_A);
		else if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z)
			row = int'(c - ASCII_UPPER_A);
		else if (c >= ASCII_ZERO && c <= ASCII_NINE)
			row = int'(DIGIT_ROW) + int'(c - ASCII_ZERO);

		// anything else: one flagged empty element, message gap dropped
		if (row < 0 && c != ASCII_SPACE) begin
			el = '{NO_UNITS, NO_UNITS, 1'b1, 1'b1};
			due_elements.push_back(el);
			return;
		end

		if (row >= 0) begin
			word = morse_words[row];
			for (k = 0; k < word.len(); k++) begin
				el = '{(word[k] == "-") ? DASH_MARK : DOT_MARK, SYM_GAP, 1'b0, 1'b0};
				due_elements.push_back(el);
			end
		end
		el = '{NO_UNITS, CHAR_GAP, 1'b0, !msg_end};
		due_elements.push_back(el);
		if (msg_end) begin
			el = '{NO_UNITS, MSG_GAP, 1'b0, 1'b1};
			due_elements.push_back(el);
		end
	endtask

	// Compare elements first, then take any new item at the same edge
	always @(posedge clk) begin
		element_t want;
		if (arst_n) begin
			if (strobe !== 1'b0) begin
				if (due_elements.size() == 0) begin
					report_mismatch($sformatf("element with none due: mark %0d gap %0d unsup %b last %b",
						mark_units, gap_units, unsupported, last));
				end else begin
					want = due_elements.pop_front();
					if (mark_units !== want.mark)
						report_mismatch($sformatf("mark_units %0d, want %0d", mark_units, want.mark));
					if (gap_units !== want.gap)
						report_mismatch($sformatf("gap_units %0d, want %0d", gap_units, want.gap));
					if (unsupported !== want.unsup)
						report_mismatch($sformatf("unsupported %b, want %b", unsupported, want.unsup));
					if (last !== want.fin)
						report_mismatch($sformatf("last %b, want %b", last, want.fin));
				end
			end
			if (start === 1'b1 && busy === 1'b0)
				expand_character(character, ends_message);
			outstanding = due_elements.size();
		end
	end

endmodule

FILE: tb/morse_code_keyer_top_test.sv
// Testbench top for the Morse keyer: clock, reset, character stimulus and verdict.
`timescale 1ns / 1ps
module morse_code_keyer_top_test;
	import mck_pkg::*;

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       start        = 1'b0;
	logic [7:0] character    = 8'h00;
	logic       ends_message = 1'b0;
	logic       busy;
	logic       strobe;
	logic [1:0] mark_units;
	logic [1:0] gap_units;
	logic       unsupported;
	logic       last;
	int         fail_count;
	int         outstanding;
	int         idle_pct;

	// {ends_message, character}: case and range edges, space, unsupported codes
	logic [8:0] directed_items [20] = '{
		{1'b0, 8'h61}, {1'b0, 8'h7a}, {1'b0, 8'h41}, {1'b1, 8'h5a},
		{1'b0, 8'h30}, {1'b1, 8'h39}, {1'b1, 8'h37}, {1'b0, 8'h20},
		{1'b1, 8'h20}, {1'b0, 8'h00}, {1'b1, 8'hff}, {1'b0, 8'h40},
		{1'b0, 8'h5b}, {1'b0, 8'h60}, {1'b1, 8'h7b}, {1'b0, 8'h2f},
		{1'b0, 8'h3a}, {1'b0, 8'h1f}, {1'b0, 8'h21}, {1'b1, 8'h80}
	};

	morse_code_keyer_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.character    (character),
		.ends_message (ends_message),
		.strobe       (strobe),
		.mark_units   (mark_units),
		.gap_units    (gap_units),
		.unsupported  (unsupported),
		.last         (last)
	);

	keyer_element_checker element_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.character    (character),
		.ends_message (ends_message),
		.strobe       (strobe),
		.mark_units   (mark_units),
		.gap_units    (gap_units),
		.unsupported  (unsupported),
		.last         (last),
		.fail_count   (fail_count),
		.outstanding  (outstanding)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Mostly letters and digits, some spaces, the rest any code at all
	function automatic logic [7:0] pick_character();
		int sel;
		sel = $urandom_range(9);
		case (sel)
			0, 1: pick_character = ASCII_LOWER_A + 8'($urandom_range(25));
			2, 3: pick_character = ASCII_UPPER_A + 8'($urandom_range(25));
			4, 5: pick_character = ASCII_ZERO + 8'($urandom_range(9));
			6:    pick_character = ASCII_SPACE;
			default: pick_character = 8'($urandom_range(255));
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after the item is taken, or after a sender gap
	task automatic key_character(input logic [7:0] c, input logic msg_end);
		start        <= 1'b1;
		character    <= c;
		ends_message <= msg_end;
		while (busy) @(negedge clk);
		@(negedge clk);
		// sender gap, so the next request lands on any step of this character or after it
		if ($urandom_range(99) < idle_pct) begin
			start        <= 1'b0;
			character    <= 8'($urandom);
			ends_message <= 1'($urandom);
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
	endtask

	initial begin
		int phase;
		int i;
		idle_pct = 27;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_items[j])
			key_character(directed_items[j][7:0], directed_items[j][8]);

		// sender idles now and then, often, then never
		for (phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 27 : (phase == 1) ? 72 : 0;
			for (i = 0; i < 70; i++)
				key_character(pick_character(), 1'($urandom));
		end
		start <= 1'b0;

		wait (outstanding == 0);
		repeat (12) @(negedge clk);
		if (fail_count == 0)
			$display("morse_code_keyer_top: match");
		else
			$display("morse_code_keyer_top: mismatch");
		$finish;
	end

	// Watchdog
	initial begin
		#2ms;
		$display("morse_code_keyer_top: mismatch");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/mck_pkg.sv
hdl/mck_decode.sv
hdl/morse_code_keyer_top.sv
tb/keyer_element_checker.sv
tb/morse_code_keyer_top_test.sv
